// ===== rtl/api_tx_frame_encoder_defines.svh =====
// Assertion macros for the API transmit frame encoder.
`ifndef API_TX_FRAME_ENCODER_DEFINES_SVH
`define API_TX_FRAME_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define API_TX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define API_TX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define API_TX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define API_TX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/api_tx_pkg.sv =====
package api_tx_pkg;

    localparam int unsigned MAX_FRAME    = 15;
    localparam int unsigned LEN_W        = 4;
    localparam int unsigned TARGET_COUNT = 5;

    localparam logic [7:0] START_BYTE    = 8'h7E;
    localparam logic [7:0] BASE_LEN      = 8'h05;
    localparam logic [7:0] FRAME_TYPE    = 8'h01;
    localparam logic [7:0] CMD_MOTORS    = 8'h01;
    localparam logic [7:0] CMD_FORMATION = 8'h02;
    localparam logic [7:0] CHECK_BASE    = 8'hFF;

    localparam logic [7:0] RST_ADDR_HIGH = 8'hA2;
    localparam logic [7:0] RST_ADDR_LOW  = 8'hA0;
    localparam logic [7:0] RST_FRAME_ID  = 8'h01;
    localparam logic [7:0] RST_OPTIONS   = 8'h01;

    localparam logic [LEN_W-1:0] LEN_POSITION = 4'd15;
    localparam logic [LEN_W-1:0] LEN_COMMAND  = 4'd11;

    // configuration register indexes
    localparam logic [2:0] REG_ADDR_HIGH = 3'd0;
    localparam logic [2:0] REG_ADDR_LOW  = 3'd1;
    localparam logic [2:0] REG_FRAME_ID  = 3'd2;
    localparam logic [2:0] REG_OPTIONS   = 3'd3;

    localparam logic ACT_POSITION = 1'b0;
    localparam logic ACT_COMMAND  = 1'b1;

    localparam logic [2:0] ORD_DISABLE = 3'd0;
    localparam logic [2:0] ORD_ENABLE  = 3'd1;
    localparam logic [2:0] ORD_FORM0   = 3'd2;
    localparam logic [2:0] ORD_FORM1   = 3'd3;
    localparam logic [2:0] ORD_FORM2   = 3'd4;

    typedef logic [7:0] t_byte;

endpackage

// ===== rtl/api_tx_frame_encoder.sv =====
// API-mode 16-bit-address transmit frame encoder. Each accepted request
// (position or command) becomes one frame streamed a byte per transfer:
// 15 bytes for a position, 11 for a command, with o_last_byte on the
// trailing checksum. Command requests with an unknown order code and any
// request with a target at or above TARGET_COUNT give no bytes. The whole
// frame and its checksum are built combinationally from the input
// register into a 15-byte shift register, which feeds the output register
// one byte per cycle while the output is not stalled. The first byte
// passes the input, shift and output registers in turn; frames follow
// each other without gaps, paced by the single byte-wide output register,
// while the input register holds the next request. A dropped request
// waits there until the shift register is free. Configuration writes are
// taken at any time but should only be issued while no frame is pending.
`include "api_tx_frame_encoder_defines.svh"

module api_tx_frame_encoder #(
    parameter int unsigned TARGET_COUNT = api_tx_pkg::TARGET_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    // requests
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic signed [16:0] i_pos_x,
    input  logic signed [16:0] i_pos_y,
    input  logic [2:0]         i_order_code,
    input  logic [2:0]         i_target,
    // frame bytes
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_byte
);

    localparam int unsigned NF = api_tx_pkg::MAX_FRAME;
    localparam int unsigned LW = api_tx_pkg::LEN_W;

    // configuration registers
    api_tx_pkg::t_byte r_addr_high;
    api_tx_pkg::t_byte r_addr_low;
    api_tx_pkg::t_byte r_frame_id;
    api_tx_pkg::t_byte r_options;

    // input register
    logic               r_req_valid;
    logic               r_action;
    logic signed [16:0] r_pos_x;
    logic signed [16:0] r_pos_y;
    logic [2:0]         r_order_code;
    logic [2:0]         r_target;

    // frame shift register
    api_tx_pkg::t_byte  r_frame [NF];
    logic               r_busy;
    logic [LW-1:0]      r_left;

    // output register
    logic               r_out_valid;
    api_tx_pkg::t_byte  r_out_byte;
    logic               r_out_last;

    // frame builder
    api_tx_pkg::t_byte  n_frame [NF];
    logic [LW-1:0]      n_len;
    logic               n_keep;

    logic               out_free;
    logic               emit;
    logic               frame_free;
    logic               req_take;
    logic               in_xfer;

    logic               x_neg;
    logic               y_neg;
    logic [16:0]        x_abs;
    logic [16:0]        y_abs;
    logic [15:0]        x_mag;
    logic [15:0]        y_mag;
    logic               tgt_ok;
    api_tx_pkg::t_byte  cmd_op;
    api_tx_pkg::t_byte  cmd_arg;
    logic               cmd_ok;
    api_tx_pkg::t_byte  sum;

    assign out_free   = !r_out_valid || !i_stall;
    assign emit       = r_busy && out_free;
    assign frame_free = !r_busy || (emit && (r_left == LW'(1)));
    assign req_take   = r_req_valid && frame_free;
    assign o_stall    = r_req_valid && !frame_free;
    assign in_xfer    = i_valid && !o_stall;

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

    // coordinate magnitudes; -65536 saturates to 0xFFFF
    always_comb begin
        x_neg = r_pos_x[16];
        y_neg = r_pos_y[16];
        x_abs = x_neg ? (~r_pos_x + 17'd1) : r_pos_x;
        y_abs = y_neg ? (~r_pos_y + 17'd1) : r_pos_y;
        x_mag = x_abs[16] ? 16'hFFFF : x_abs[15:0];
        y_mag = y_abs[16] ? 16'hFFFF : y_abs[15:0];
    end

    always_comb begin
        tgt_ok = ({6'd0, r_target} < 9'(TARGET_COUNT));
        cmd_ok = 1'b1;
        case (r_order_code)
            api_tx_pkg::ORD_DISABLE, api_tx_pkg::ORD_ENABLE: begin
                cmd_op  = api_tx_pkg::CMD_MOTORS;
                cmd_arg = {5'd0, r_order_code};
            end
            api_tx_pkg::ORD_FORM0, api_tx_pkg::ORD_FORM1, api_tx_pkg::ORD_FORM2: begin
                cmd_op  = api_tx_pkg::CMD_FORMATION;
                cmd_arg = {5'd0, r_order_code - api_tx_pkg::ORD_FORM0};
            end
            default: begin
                cmd_op  = '0;
                cmd_arg = '0;
                cmd_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < NF; i++) begin
            n_frame[i] = '0;
        end
        n_frame[0] = api_tx_pkg::START_BYTE;
        n_frame[1] = 8'h00;
        n_frame[3] = api_tx_pkg::FRAME_TYPE;
        n_frame[4] = r_frame_id;
        n_frame[5] = r_addr_high;
        n_frame[6] = r_addr_low + {5'd0, r_target};
        n_frame[7] = r_options;
        if (r_action == api_tx_pkg::ACT_POSITION) begin
            n_frame[2]  = api_tx_pkg::BASE_LEN + 8'd6;
            n_frame[8]  = {7'd0, x_neg};
            n_frame[9]  = x_mag[15:8];
            n_frame[10] = x_mag[7:0];
            n_frame[11] = {7'd0, y_neg};
            n_frame[12] = y_mag[15:8];
            n_frame[13] = y_mag[7:0];
            sum = n_frame[3] + n_frame[4] + n_frame[5] + n_frame[6] + n_frame[7]
                + n_frame[8] + n_frame[9] + n_frame[10] + n_frame[11]
                + n_frame[12] + n_frame[13];
            n_frame[14] = api_tx_pkg::CHECK_BASE - sum;
            n_len  = api_tx_pkg::LEN_POSITION;
            n_keep = tgt_ok;
        end else begin
            n_frame[2] = api_tx_pkg::BASE_LEN + 8'd2;
            n_frame[8] = cmd_op;
            n_frame[9] = cmd_arg;
            sum = n_frame[3] + n_frame[4] + n_frame[5] + n_frame[6] + n_frame[7]
                + n_frame[8] + n_frame[9];
            n_frame[10] = api_tx_pkg::CHECK_BASE - sum;
            n_len  = api_tx_pkg::LEN_COMMAND;
            n_keep = tgt_ok && cmd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_high <= api_tx_pkg::RST_ADDR_HIGH;
            r_addr_low  <= api_tx_pkg::RST_ADDR_LOW;
            r_frame_id  <= api_tx_pkg::RST_FRAME_ID;
            r_options   <= api_tx_pkg::RST_OPTIONS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                api_tx_pkg::REG_ADDR_HIGH: r_addr_high <= i_cfg_data;
                api_tx_pkg::REG_ADDR_LOW:  r_addr_low  <= i_cfg_data;
                api_tx_pkg::REG_FRAME_ID:  r_frame_id  <= i_cfg_data;
                api_tx_pkg::REG_OPTIONS:   r_options   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (in_xfer) begin
            r_req_valid <= 1'b1;
        end else if (req_take) begin
            r_req_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_action     <= i_action;
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_order_code <= i_order_code;
            r_target     <= i_target;
        end
    end

    // frame shift register: byte 0 is the next one out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (req_take && n_keep) begin
            r_busy <= 1'b1;
            r_left <= n_len;
        end else if (emit) begin
            r_busy <= (r_left != LW'(1));
            r_left <= r_left - LW'(1);
        end
        if (req_take && n_keep) begin
            r_frame <= n_frame;
        end else if (emit) begin
            for (int i = 0; i < NF - 1; i++) begin
                r_frame[i] <= r_frame[i+1];
            end
            r_frame[NF-1] <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_busy;
            r_out_last  <= r_busy && (r_left == LW'(1));
        end
        if (emit) begin
            r_out_byte <= r_frame[0];
        end
    end

    `API_TX_ASSERT_NOW(a_left_range, i_clk, i_rst_n, r_busy,
        (r_left != '0) && (r_left <= LW'(NF)), "frame byte count out of range")
    `API_TX_ASSERT_NEXT(a_last_marked, i_clk, i_rst_n, emit && (r_left == LW'(1)),
        r_out_valid && r_out_last, "checksum byte not flagged last")
    `API_TX_ASSERT_NEXT(a_mid_unmarked, i_clk, i_rst_n, emit && (r_left != LW'(1)),
        r_out_valid && !r_out_last, "last flag on a byte inside the frame")
    `API_TX_ASSERT_NOW(a_hold_request, i_clk, i_rst_n, r_req_valid && r_busy && !emit,
        o_stall, "request taken while frame still pending")

endmodule
